FILE: hw/rtl/aml_sleep_type_extractor_assert.svh
// Assertion macros for the sleep type extractor.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef AML_SLEEP_TYPE_EXTRACTOR_ASSERT_SVH
`define AML_SLEEP_TYPE_EXTRACTOR_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define AML_STE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define AML_STE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/aml_ste_pkg.sv
// Shared types, constants and the integer opcode decoder for the sleep type extractor.
// No dependencies.
`timescale 1ns / 1ps

package aml_ste_pkg;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NONAME  = 3'd1;
	localparam logic [2:0] ST_NOTPKG  = 3'd2;
	localparam logic [2:0] ST_BADELEM = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;

	// The name "_S5_": the three bytes seen before the final underscore.
	localparam logic [23:0] NAME_HEAD = 24'h5F5335;
	localparam logic [7:0]  NAME_TAIL = 8'h5F;

	localparam logic [7:0] PACKAGE_OP   = 8'h12;
	localparam logic [7:0] ZERO_OP      = 8'h00;
	localparam logic [7:0] ONE_OP       = 8'h01;
	localparam logic [7:0] ONES_OP      = 8'hFF;
	localparam logic [7:0] BYTE_PREFIX  = 8'h0A;
	localparam logic [7:0] WORD_PREFIX  = 8'h0B;
	localparam logic [7:0] DWORD_PREFIX = 8'h0C;
	localparam logic [7:0] QWORD_PREFIX = 8'h0E;
	localparam logic [7:0] MIN_ELEMENTS = 8'd2;

	// Result queue depth.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  sleep_type_a;
		logic [2:0]  sleep_type_b;
		logic [15:0] control_word_a;
		logic [15:0] control_word_b;
	} out_word_t;

	// One queued result as the parser leaves it.
	typedef struct packed {
		logic [2:0] status;
		logic [2:0] type_a;
		logic [2:0] type_b;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Decoded integer opcode.
	typedef struct packed {
		logic       known;
		logic       immediate;
		logic [2:0] value;
		logic [2:0] extra;
	} op_class_t;

	function automatic op_class_t classify_op(input logic [7:0] op);
		op_class_t c;
		c = '0;
		case (op)
			ZERO_OP: begin
				c.known = 1'b1;
				c.immediate = 1'b1;
				c.value = 3'd0;
			end
			ONE_OP: begin
				c.known = 1'b1;
				c.immediate = 1'b1;
				c.value = 3'd1;
			end
			ONES_OP: begin
				c.known = 1'b1;
				c.immediate = 1'b1;
				c.value = 3'd7;
			end
			BYTE_PREFIX: begin
				c.known = 1'b1;
				c.extra = 3'd0;
			end
			WORD_PREFIX: begin
				c.known = 1'b1;
				c.extra = 3'd1;
			end
			DWORD_PREFIX: begin
				c.known = 1'b1;
				c.extra = 3'd3;
			end
			QWORD_PREFIX: begin
				c.known = 1'b1;
				c.extra = 3'd7;
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/aml_sleep_type_extractor.sv
// Top level of the _S5_ sleep type extractor: parser, result queue and output stage.
// Depends on aml_ste_pkg, aml_ste_front, aml_ste_fifo, aml_ste_back and aml_sleep_type_extractor_assert.svh.
`timescale 1ns / 1ps
`include "aml_sleep_type_extractor_assert.svh"

// Usage:
// The input channel carries the DSDT body after its 36-byte header, one word
// per byte, with last_byte set on the final byte of the table. The output
// channel carries exactly one word per table: a status, the two sleep types
// and the two PM1 control words with SLP_EN set (all zero on an error).
// The parser updates its state at the edge that accepts the byte, so a new
// byte can be taken every cycle while the result queue is not full.
// A result is pushed into a four-entry queue at the accepting edge and moves
// on to the output through a single output register once that is free.
// When the receiver stalls, results pile up in the queue; in_ready drops only
// once the queue is full, and the held output word stays stable until taken.
// After an early error the remaining bytes of the table are consumed without
// a result until the final byte rearms the search.
// Reset clears the parser to searching, empties the queue and drops out_valid;
// no clearing pass is needed.
module aml_sleep_type_extractor (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  aml_ste_pkg::in_word_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output aml_ste_pkg::out_word_t out_data
);
	import aml_ste_pkg::*;

	q_push_t   q_push;
	q_status_t q_stat;
	q_entry_t  head;
	logic      pop;

	aml_ste_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.q_push   (q_push)
	);

	aml_ste_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	aml_ste_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`AML_STE_ASSERT_SAME(a_err_fields_zero, out_valid && out_data.status != ST_OK,
		out_data.control_word_a == 16'd0 && out_data.control_word_b == 16'd0 &&
		out_data.sleep_type_a == 3'd0 && out_data.sleep_type_b == 3'd0,
		"error result carries nonzero fields")
	`AML_STE_ASSERT_SAME(a_ok_words, out_valid && out_data.status == ST_OK,
		out_data.control_word_a == {2'b00, 1'b1, out_data.sleep_type_a, 10'd0} &&
		out_data.control_word_b == {2'b00, 1'b1, out_data.sleep_type_b, 10'd0},
		"control word does not match sleep type")
	`AML_STE_ASSERT_SAME(a_status_range, out_valid,
		out_data.status == ST_OK || out_data.status == ST_NONAME ||
		out_data.status == ST_NOTPKG || out_data.status == ST_BADELEM ||
		out_data.status == ST_TRUNC,
		"status code out of range")
	`AML_STE_ASSERT_NEXT(a_queue_stays_empty, q_stat.empty && !q_push.valid,
		q_stat.empty, "queue filled without a push")

endmodule

FILE: hw/rtl/aml_ste_front.sv
// Byte parser: searches for the _S5_ name, walks the package header and
// decodes two integers, pushing one result per table. Depends on aml_ste_pkg.
`timescale 1ns / 1ps

module aml_ste_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  aml_ste_pkg::in_word_t in_data,
	input  aml_ste_pkg::q_status_t q_stat,
	output aml_ste_pkg::q_push_t  q_push
);
	import aml_ste_pkg::*;

	typedef enum logic [11:0] {
		PH_SEARCH    = 12'h001,
		PH_PKG_OP    = 12'h002,
		PH_PKG_LEAD  = 12'h004,
		PH_PKG_EXTRA = 12'h008,
		PH_COUNT     = 12'h010,
		PH_A_OP      = 12'h020,
		PH_A_FIRST   = 12'h040,
		PH_A_REST    = 12'h080,
		PH_B_OP      = 12'h100,
		PH_B_FIRST   = 12'h200,
		PH_B_REST    = 12'h400,
		PH_DRAIN     = 12'h800
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] recent_q, recent_d;
	logic [2:0]  skip_q, skip_d;
	logic [2:0]  first_q, first_d;
	logic [2:0]  second_q, second_d;
	logic        have;
	logic [2:0]  st;
	logic        accept;
	op_class_t   op;
	logic [7:0]  b;
	logic        last;

	// Every word yields at most one result, so a free queue slot is enough.
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.data_byte;
	assign last     = in_data.last_byte;
	assign op       = classify_op(b);

	always_comb begin
		phase_d  = phase_q;
		recent_d = recent_q;
		skip_d   = skip_q;
		first_d  = first_q;
		second_d = second_q;
		have     = 1'b0;
		st       = ST_OK;
		case (phase_q)
			PH_SEARCH: begin
				if (recent_q == NAME_HEAD && b == NAME_TAIL) begin
					phase_d = PH_PKG_OP;
				end
				recent_d = {recent_q[15:0], b};
			end
			PH_PKG_OP: begin
				if (b == PACKAGE_OP) begin
					phase_d = PH_PKG_LEAD;
				end else begin
					have = 1'b1;
					st = ST_NOTPKG;
				end
			end
			PH_PKG_LEAD: begin
				skip_d = {1'b0, b[7:6]};
				phase_d = (b[7:6] != 2'd0) ? PH_PKG_EXTRA : PH_COUNT;
			end
			PH_PKG_EXTRA: begin
				skip_d = skip_q - 3'd1;
				if (skip_q == 3'd1) begin
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (b >= MIN_ELEMENTS) begin
					phase_d = PH_A_OP;
				end else begin
					have = 1'b1;
					st = ST_BADELEM;
				end
			end
			PH_A_OP: begin
				if (!op.known) begin
					have = 1'b1;
					st = ST_BADELEM;
				end else if (op.immediate) begin
					first_d = op.value;
					phase_d = PH_B_OP;
				end else begin
					skip_d = op.extra;
					phase_d = PH_A_FIRST;
				end
			end
			PH_A_FIRST: begin
				first_d = b[2:0];
				phase_d = (skip_q != 3'd0) ? PH_A_REST : PH_B_OP;
			end
			PH_A_REST: begin
				skip_d = skip_q - 3'd1;
				if (skip_q == 3'd1) begin
					phase_d = PH_B_OP;
				end
			end
			PH_B_OP: begin
				if (!op.known) begin
					have = 1'b1;
					st = ST_BADELEM;
				end else if (op.immediate) begin
					second_d = op.value;
					have = 1'b1;
				end else begin
					skip_d = op.extra;
					phase_d = PH_B_FIRST;
				end
			end
			PH_B_FIRST: begin
				second_d = b[2:0];
				if (skip_q != 3'd0) begin
					phase_d = PH_B_REST;
				end else begin
					have = 1'b1;
				end
			end
			PH_B_REST: begin
				skip_d = skip_q - 3'd1;
				if (skip_q == 3'd1) begin
					have = 1'b1;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		// The final byte closes out any table that has not reported yet.
		if (!have && last && phase_d != PH_DRAIN) begin
			have = 1'b1;
			st = (phase_d == PH_SEARCH) ? ST_NONAME : ST_TRUNC;
		end
	end

	always_comb begin
		q_push.valid        = accept && have;
		q_push.entry.status = st;
		q_push.entry.type_a = (st == ST_OK) ? first_d : 3'd0;
		q_push.entry.type_b = (st == ST_OK) ? second_d : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			recent_q <= '0;
			skip_q   <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (last) begin
				phase_q  <= PH_SEARCH;
				recent_q <= '0;
				skip_q   <= '0;
				first_q  <= '0;
				second_q <= '0;
			end else begin
				phase_q  <= have ? PH_DRAIN : phase_d;
				recent_q <= recent_d;
				skip_q   <= skip_d;
				first_q  <= first_d;
				second_q <= second_d;
			end
		end
	end

endmodule

FILE: hw/rtl/aml_ste_fifo.sv
// Short result queue between the parser and the output stage.
// Depends on aml_ste_pkg.
`timescale 1ns / 1ps

module aml_ste_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aml_ste_pkg::q_push_t   q_push,
	input  logic                   pop,
	output aml_ste_pkg::q_entry_t  head,
	output aml_ste_pkg::q_status_t q_stat
);
	import aml_ste_pkg::*;

	q_entry_t        slots_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_pop;

	assign q_stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = slots_q[rd_ptr_q];
	assign do_pop       = pop && !q_stat.empty;

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			slots_q[wr_ptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (q_push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!q_push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/aml_ste_back.sv
// Output stage: builds the PM1 control words from a queued result and holds
// the outgoing word until it is taken. Depends on aml_ste_pkg.
`timescale 1ns / 1ps

module aml_ste_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aml_ste_pkg::q_entry_t  head,
	input  aml_ste_pkg::q_status_t q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output aml_ste_pkg::out_word_t out_data
);
	import aml_ste_pkg::*;

	logic      out_valid_q;
	out_word_t out_data_q;
	out_word_t next_word;
	logic      is_ok;

	assign pop   = !q_stat.empty && (!out_valid_q || out_ready);
	assign is_ok = (head.status == ST_OK);

	// SLP_TYP sits in bits 12:10 and SLP_EN is bit 13.
	always_comb begin
		next_word.status         = head.status;
		next_word.sleep_type_a   = is_ok ? head.type_a : 3'd0;
		next_word.sleep_type_b   = is_ok ? head.type_b : 3'd0;
		next_word.control_word_a = is_ok ? {2'b00, 1'b1, head.type_a, 10'd0} : 16'd0;
		next_word.control_word_b = is_ok ? {2'b00, 1'b1, head.type_b, 10'd0} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= next_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: tb/s5_result_checker.sv
// Checker for the _S5_ sleep type extractor: watches both channels, predicts each result word
// from the accepted bytes and compares it field by field. Depends on aml_ste_pkg.
`timescale 1ns / 1ps

module s5_result_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  aml_ste_pkg::in_word_t  in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  aml_ste_pkg::out_word_t out_data,
	output int                     fail_count,
	output int                     words_due
);
	import aml_ste_pkg::*;

	localparam logic [15:0] SLP_EN    = 16'h2000;
	localparam int          TYP_SHIFT = 10;

	typedef enum logic [3:0] {
		SEEK_NAME, WANT_PKG, PKG_LEAD, PKG_EXTRA, ELEM_COUNT,
		A_OP, A_FIRST, A_REST, B_OP, B_FIRST, B_REST, DRAIN
	} parse_phase_t;

	logic [23:0]  recent;
	parse_phase_t phase;
	logic [3:0]   skip;
	logic [2:0]   type_a;
	logic [2:0]   type_b;
	out_word_t    due_q[$];

	initial fail_count = 0;

	function automatic void rearm();
		recent = '0;
		phase  = SEEK_NAME;
		skip   = '0;
		type_a = '0;
		type_b = '0;
	endfunction

	// Data bytes that follow an integer opcode; -1 for an opcode that is not an integer,
	// 0 for one that carries its value itself.
	function automatic int int_length(input logic [7:0] op, output logic [2:0] val);
		val = '0;
		case (op)
			ZERO_OP: return 0;
			ONE_OP: begin
				val = 3'd1;
				return 0;
			end
			ONES_OP: begin
				val = 3'd7;
				return 0;
			end
			BYTE_PREFIX: return 1;
			WORD_PREFIX: return 2;
			DWORD_PREFIX: return 4;
			QWORD_PREFIX: return 8;
			default: return -1;
		endcase
	endfunction

	function automatic logic [15:0] control_word(input logic [2:0] typ);
		return SLP_EN | (16'(typ) << TYP_SHIFT);
	endfunction

	// Advances the parser by one byte; returns 1 when the byte yields a result word.
	function automatic bit parse_byte(input logic [7:0] b, input logic fin, output out_word_t res);
		bit         have;
		logic [2:0] st;
		logic [2:0] val;
		int         n;
		have = 0;
		st = ST_OK;
		res = '0;
		case (phase)
			SEEK_NAME: begin
				if (recent == NAME_HEAD && b == NAME_TAIL)
					phase = WANT_PKG;
				recent = {recent[15:0], b};
			end
			WANT_PKG: begin
				if (b == PACKAGE_OP) begin
					phase = PKG_LEAD;
				end else begin
					have = 1;
					st = ST_NOTPKG;
				end
			end
			PKG_LEAD: begin
				skip = {2'b00, b[7:6]};
				phase = (skip != 0) ? PKG_EXTRA : ELEM_COUNT;
			end
			PKG_EXTRA: begin
				skip = skip - 4'd1;
				if (skip == 0)
					phase = ELEM_COUNT;
			end
			ELEM_COUNT: begin
				if (b >= MIN_ELEMENTS) begin
					phase = A_OP;
				end else begin
					have = 1;
					st = ST_BADELEM;
				end
			end
			A_OP: begin
				n = int_length(b, val);
				if (n < 0) begin
					have = 1;
					st = ST_BADELEM;
				end else if (n == 0) begin
					type_a = val;
					phase = B_OP;
				end else begin
					skip = 4'(n - 1);
					phase = A_FIRST;
				end
			end
			A_FIRST: begin
				type_a = b[2:0];
				phase = (skip != 0) ? A_REST : B_OP;
			end
			A_REST: begin
				skip = skip - 4'd1;
				if (skip == 0)
					phase = B_OP;
			end
			B_OP: begin
				n = int_length(b, val);
				if (n < 0) begin
					have = 1;
					st = ST_BADELEM;
				end else if (n == 0) begin
					type_b = val;
					have = 1;
				end else begin
					skip = 4'(n - 1);
					phase = B_FIRST;
				end
			end
			B_FIRST: begin
				type_b = b[2:0];
				if (skip != 0)
					phase = B_REST;
				else
					have = 1;
			end
			B_REST: begin
				skip = skip - 4'd1;
				if (skip == 0)
					have = 1;
			end
			default: begin
			end
		endcase

		// The final byte closes the table unless a result was already given.
		if (!have && fin && phase != DRAIN) begin
			have = 1;
			st = (phase == SEEK_NAME) ? ST_NONAME : ST_TRUNC;
		end
		if (have) begin
			res.status = st;
			if (st == ST_OK) begin
				res.sleep_type_a = type_a;
				res.sleep_type_b = type_b;
				res.control_word_a = control_word(type_a);
				res.control_word_b = control_word(type_b);
			end
		end
		if (fin)
			rearm();
		else if (have)
			phase = DRAIN;
		return have;
	endfunction

	task automatic report(input string msg);
		$display("%0t ERROR %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_word(input out_word_t got, input out_word_t want);
		if (got.status !== want.status)
			report($sformatf("status got %0d expected %0d", got.status, want.status));
		if (got.sleep_type_a !== want.sleep_type_a)
			report($sformatf("sleep_type_a got %0d expected %0d",
				got.sleep_type_a, want.sleep_type_a));
		if (got.sleep_type_b !== want.sleep_type_b)
			report($sformatf("sleep_type_b got %0d expected %0d",
				got.sleep_type_b, want.sleep_type_b));
		if (got.control_word_a !== want.control_word_a)
			report($sformatf("control_word_a got %h expected %h",
				got.control_word_a, want.control_word_a));
		if (got.control_word_b !== want.control_word_b)
			report($sformatf("control_word_b got %h expected %h",
				got.control_word_b, want.control_word_b));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t pred;
		out_word_t oldest;
		if (!arst_n) begin
			rearm();
			due_q.delete();
			words_due <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (parse_byte(in_data.data_byte, in_data.last_byte, pred))
					due_q.push_back(pred);
			end
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					report($sformatf("unexpected result word %h", out_data));
				end else begin
					oldest = due_q.pop_front();
					compare_word(out_data, oldest);
				end
			end
			words_due <= due_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// Top of the sleep type extractor testbench: clock, reset, table byte stimulus and verdict.
// Depends on aml_ste_pkg, aml_sleep_type_extractor and s5_result_checker.
`timescale 1ns / 1ps

module tb_top;
	import aml_ste_pkg::*;

	localparam int RANDOM_BYTES = 1850;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	int        fail_count;
	int        words_due;
	int        bytes_sent = 0;
	bit        steady = 0;
	logic [7:0] table_bytes[$];

	aml_sleep_type_extractor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	s5_result_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.words_due (words_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL aml_sleep_type_extractor");
		$finish;
	end

	// The receiver stalls at random except during the steady stretch.
	initial begin
		forever begin
			@(posedge clk);
			out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_byte: fin};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_table();
		for (int i = 0; i < table_bytes.size(); i++)
			put_byte(table_bytes[i], i == table_bytes.size() - 1);
		table_bytes.delete();
	endtask

	task automatic add_name();
		table_bytes.push_back(NAME_HEAD[23:16]);
		table_bytes.push_back(NAME_HEAD[15:8]);
		table_bytes.push_back(NAME_HEAD[7:0]);
		table_bytes.push_back(NAME_TAIL);
	endtask

	// Noise leans toward the name's characters so that near misses show up.
	task automatic add_noise(input int n);
		repeat (n) begin
			case ($urandom_range(5))
				0: table_bytes.push_back(NAME_TAIL);
				1: table_bytes.push_back(NAME_HEAD[15:8]);
				2: table_bytes.push_back(NAME_HEAD[7:0]);
				default: table_bytes.push_back(8'($urandom_range(255)));
			endcase
		end
	endtask

	task automatic add_int();
		int pick;
		int data_len;
		pick = $urandom_range(19);
		data_len = 0;
		if (pick < 3) begin
			table_bytes.push_back(ZERO_OP);
		end else if (pick < 5) begin
			table_bytes.push_back(ONE_OP);
		end else if (pick < 7) begin
			table_bytes.push_back(ONES_OP);
		end else if (pick < 10) begin
			table_bytes.push_back(BYTE_PREFIX);
			data_len = 1;
		end else if (pick < 13) begin
			table_bytes.push_back(WORD_PREFIX);
			data_len = 2;
		end else if (pick < 16) begin
			table_bytes.push_back(DWORD_PREFIX);
			data_len = 4;
		end else if (pick < 19) begin
			table_bytes.push_back(QWORD_PREFIX);
			data_len = 8;
		end else begin
			table_bytes.push_back(8'($urandom_range(255)));
		end
		repeat (data_len)
			table_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic build_s5_table();
		logic [7:0] lead;
		int keep;
		add_noise($urandom_range(5));
		if ($urandom_range(9) == 0) begin
			table_bytes.push_back(NAME_HEAD[23:16]);
			table_bytes.push_back(NAME_HEAD[15:8]);
		end
		add_name();
		table_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : PACKAGE_OP);
		lead = 8'($urandom_range(255));
		table_bytes.push_back(lead);
		repeat (lead[7:6])
			table_bytes.push_back(8'($urandom_range(255)));
		if ($urandom_range(7) == 0)
			table_bytes.push_back(8'($urandom_range(1)));
		else
			table_bytes.push_back(8'($urandom_range(255, 2)));
		add_int();
		add_int();
		add_noise($urandom_range(3));
		// Some tables end early, at any point after their first byte.
		if ($urandom_range(6) == 0) begin
			keep = $urandom_range(table_bytes.size(), 1);
			while (table_bytes.size() > keep)
				void'(table_bytes.pop_back());
		end
	endtask

	initial begin : stimulus
		int tables;
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A one-byte table with no name in it.
		table_bytes.push_back(ZERO_OP);
		send_table();
		// The table ends on the last character of the name.
		add_name();
		send_table();
		// Longest length prefix, largest count, Ones then One, result on the final byte.
		add_name();
		table_bytes.push_back(PACKAGE_OP);
		table_bytes.push_back(8'hC0);
		repeat (3) table_bytes.push_back(8'($urandom_range(255)));
		table_bytes.push_back(8'hFF);
		table_bytes.push_back(ONES_OP);
		table_bytes.push_back(ONE_OP);
		send_table();
		// Not a package: early error, then the rest of the table is ignored.
		add_name();
		table_bytes.push_back(8'h13);
		table_bytes.push_back(NAME_TAIL);
		send_table();
		// Too few elements, followed by a byte that must be ignored.
		add_name();
		table_bytes.push_back(PACKAGE_OP);
		table_bytes.push_back(8'h00);
		table_bytes.push_back(8'h01);
		table_bytes.push_back(ZERO_OP);
		send_table();

		tables = 0;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			steady = (tables >= 40 && tables < 60);
			if ($urandom_range(3) != 0)
				build_s5_table();
			else
				add_noise($urandom_range(12, 1));
			send_table();
			tables++;
		end
		steady = 0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS aml_sleep_type_extractor");
		else
			$display("FAIL aml_sleep_type_extractor");
		$finish;
	end

endmodule
